// ----- rtl/rau_pkg.sv -----
package rau_pkg;

  localparam int WIDTH = 32;
  localparam int MW    = 64;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_CMP = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_PREP,
    S_GCD,
    S_DIVM,
    S_DIVD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic        greater;
    logic        less;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic          start;
    logic [MW-1:0] dividend;
    logic [MW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [MW-1:0] quot;
    logic [MW-1:0] rem;
  } div_rsp_t;

endpackage

// ----- rtl/rau_if.sv -----
interface rau_in_if;
  import rau_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [31:0] b_den;
  modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic        greater;
  logic        less;
  logic [1:0]  status;
  modport source (output valid, res_num, res_den, greater, less, status, input ready);
  modport sink (input valid, res_num, res_den, greater, less, status, output ready);
endinterface

// ----- rtl/rational_arithmetic_unit.sv -----
// channel | dir | word fields
// in_ch   | in  | kind[2:0] a_num a_den b_num b_den (32b signed)
// out_ch  | out | res_num[31:0] res_den[30:0] greater less status[1:0]
//
// one word at a time; in_ch.ready is high only in idle
// compare, error and zero-numerator words: mul1, mul2, mul3 and prep, then done
// other words add gcd, divm and divd: each euclid remainder step is one divide in
// the shared 64-bit restoring divider, then the numerator and the denominator are
// each divided by the gcd
// synchronous active-low reset returns to idle and drops out_ch.valid
// a finished word waits in the done state while the output register is held
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);

  state_t state_r, state_nxt;

  logic [2:0]    kind_r;
  logic [31:0]   ma_r, da_r, mb_r, db_r;
  logic          sa_r, sb_r;
  logic [MW-1:0] t1_r, t2_r;
  logic [MW-1:0] m_r, d_r, x_r, y_r;
  logic          neg_r;
  res_t          res_r;
  res_t          out_r;
  logic          res_r_valid;

  div_req_t req;
  div_rsp_t rsp;

  rau_div u_div (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  // shared 32x32 multiplier, operands picked by state
  logic [31:0]   mul_a, mul_b;
  logic [MW-1:0] prod;
  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    unique case (state_r)
      S_MUL1:  begin mul_a = ma_r; mul_b = (kind_r == KIND_MUL) ? mb_r : db_r; end
      S_MUL2:  begin mul_a = (kind_r == KIND_DIV) ? da_r : mb_r;
                     mul_b = (kind_r == KIND_DIV) ? mb_r : da_r; end
      default: begin mul_a = da_r; mul_b = db_r; end
    endcase
  end

  function automatic logic [31:0] mag(input logic [31:0] v);
    mag = v[31] ? (32'd0 - v) : v;
  endfunction

  logic in_fire, out_fire, out_free;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  // output register empty or emptied at this edge
  assign out_free = !res_r_valid || out_fire;

  // combined magnitude sum/difference for add and subtract
  logic          s2;
  logic [MW-1:0] sum_m;
  logic          sum_neg;
  always_comb begin
    s2 = (kind_r == KIND_SUB) ? !sb_r : sb_r;
    if (sa_r == s2) begin
      sum_m = t1_r + t2_r; sum_neg = sa_r;
    end else if (t1_r >= t2_r) begin
      sum_m = t1_r - t2_r; sum_neg = sa_r;
    end else begin
      sum_m = t2_r - t1_r; sum_neg = s2;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_MUL3;
      S_MUL3: state_nxt = S_PREP;
      S_PREP: begin
        if ((da_r == 0) || (db_r == 0) || (kind_r == KIND_DIV && mb_r == 0)
            || kind_r[2] || m_r == 0)
          state_nxt = S_DONE;
        else state_nxt = S_GCD;
      end
      S_GCD:  if (y_r == 0) state_nxt = S_DIVM;
              else if (rsp.done && rsp.rem == 0) state_nxt = S_DIVM;
      S_DIVM: if (rsp.done) state_nxt = S_DIVD;
      S_DIVD: if (rsp.done) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // divider requests
  logic gcd_go;
  always_comb begin
    req.start    = 1'b0;
    req.dividend = x_r;
    req.divisor  = y_r;
    gcd_go       = 1'b0;
    unique case (state_r)
      S_PREP: if (state_nxt == S_GCD) begin
        req.start = 1'b1; req.dividend = m_r; req.divisor = d_r;
      end
      S_GCD: if (rsp.done && rsp.rem != 0) begin
        req.start = 1'b1; req.dividend = y_r; req.divisor = rsp.rem; gcd_go = 1'b1;
      end else if (rsp.done) begin
        req.start = 1'b1; req.dividend = m_r; req.divisor = y_r;
      end
      S_DIVM: if (rsp.done) begin
        req.start = 1'b1; req.dividend = d_r; req.divisor = x_r;
      end
      default: ;
    endcase
  end

  // result range check
  localparam logic [MW-1:0] LIM = MW'(64'd1 << (WIDTH - 1));
  logic fit;
  assign fit = (rsp.quot <= LIM - 1) && (neg_r ? (m_r <= LIM) : (m_r <= LIM - 1));

  // compare of t1 against t2 with signs
  logic cs1, cs2, cgt, clt;
  always_comb begin
    cs1 = sa_r && (t1_r != 0);
    cs2 = sb_r && (t2_r != 0);
    if (cs1 != cs2) begin
      cgt = cs2; clt = cs1;
    end else if (!cs1) begin
      cgt = t1_r > t2_r; clt = t1_r < t2_r;
    end else begin
      cgt = t1_r < t2_r; clt = t1_r > t2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_r_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_fire) res_r_valid <= 1'b0;
      if (state_r == S_DONE && out_free) res_r_valid <= 1'b1;
    end
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        kind_r <= in_ch.kind;
        ma_r   <= mag(in_ch.a_num);
        da_r   <= mag(in_ch.a_den);
        mb_r   <= mag(in_ch.b_num);
        db_r   <= mag(in_ch.b_den);
        sa_r   <= in_ch.a_num[31] != in_ch.a_den[31];
        sb_r   <= in_ch.b_num[31] != in_ch.b_den[31];
        res_r  <= '0;
      end
      S_MUL1: t1_r <= prod;
      S_MUL2: t2_r <= prod;
      default: ;
    endcase
    if (state_r == S_MUL3) begin
      if (kind_r[1:0] == 2'd2 || kind_r[1:0] == 2'd3) begin
        m_r   <= t1_r;
        neg_r <= sa_r != sb_r;
        d_r   <= (kind_r[1:0] == 2'd3) ? t2_r : prod;
      end else begin
        m_r   <= sum_m;
        neg_r <= sum_neg;
        d_r   <= prod;
      end
    end
    if (state_r == S_PREP) begin
      x_r <= m_r;
      y_r <= d_r;
      if ((da_r == 0) || (db_r == 0) || (kind_r == KIND_DIV && mb_r == 0))
        res_r.status <= ST_ZERO;
      else if (kind_r[2]) begin
        res_r.greater <= cgt;
        res_r.less    <= clt;
      end else if (m_r == 0) begin
        res_r.res_den <= 31'd1;
      end
    end
    if (gcd_go) begin
      x_r <= y_r;
      y_r <= rsp.rem;
    end else if (state_r == S_GCD && rsp.done) begin
      x_r <= y_r;
    end
    if (state_r == S_DIVM && rsp.done) m_r <= rsp.quot;
    if (state_r == S_DIVD && rsp.done) begin
      if (fit) begin
        res_r.res_num <= neg_r ? (32'd0 - m_r[31:0]) : m_r[31:0];
        res_r.res_den <= rsp.quot[30:0];
      end else begin
        res_r.status <= ST_OVF;
      end
    end
    // hand the finished word to the output register
    if (state_r == S_DONE && out_free) out_r <= res_r;
  end

  assign out_ch.valid   = res_r_valid;
  assign out_ch.res_num = out_r.res_num;
  assign out_ch.res_den = out_r.res_den;
  assign out_ch.greater = out_r.greater;
  assign out_ch.less    = out_r.less;
  assign out_ch.status  = out_r.status;

endmodule

// ----- rtl/rau_div.sv -----
// restoring divider, one quotient bit per cycle while busy
module rau_div import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [MW-1:0]         q_r, q_nxt;
  logic [MW-1:0]         r_r, r_nxt;
  logic [MW-1:0]         d_r, d_nxt;
  logic [$clog2(MW):0]   cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [MW:0]           trial;
  logic [MW:0]           shl;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shl      = {r_r, q_r[MW-1]};
    trial    = shl - {1'b0, d_r};
    if (req.start) begin
      q_nxt    = req.dividend;
      r_nxt    = '0;
      d_nxt    = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[MW]) begin
        r_nxt = trial[MW-1:0];
        q_nxt = {q_r[MW-2:0], 1'b1};
      end else begin
        r_nxt = shl[MW-1:0];
        q_nxt = {q_r[MW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ($clog2(MW)+1)'(MW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r;

endmodule
